### rtl/lpht_pkg.sv
// Shared types and constants for the pair-keyed linear probing hash table.
package lpht_pkg;

  localparam int INDEX_W    = 10;
  localparam int SUM_W      = 20;
  localparam int SLOT_OUT_W = 10;
  localparam int CFG_W      = 11;

  // 100003 * 1023 and 103 * (2^20 - 1) both fit in 27 bits, their sum in 28
  localparam int PROD_W = 27;
  localparam int HASH_W = 28;

  localparam logic [PROD_W-1:0] HASH_MUL_INDEX = 27'd100003;
  localparam logic [PROD_W-1:0] HASH_MUL_SUM   = 27'd103;

  // remainder unit: four restoring steps per cycle
  localparam int MOD_STEP   = 4;
  localparam int MOD_ITERS  = HASH_W / MOD_STEP;
  localparam int MOD_ITER_W = $clog2(MOD_ITERS);

  localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] item_index;
    logic [SUM_W-1:0]   partial_sum;
    logic               take_bit;
  } req_item_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  stored_bit;
    logic                  status;
  } rsp_item_t;

endpackage

### rtl/linear_probe_pair_hash_table.sv
// Top level: open-addressing hash table on (item_index, partial_sum) with linear probing.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall | kind, item_index, partial_sum, take_bit
//  rsp     | out       | rsp_valid/rsp_stall | found, slot, stored_bit, status
//  cfg     | in        | cfg_valid/cfg_ready | slots_in_use (11 bits), always ready
//
// One item at a time. An item goes through these steps: the two hash products are
// registered, the remainder is launched, the remainder unit runs its iterations, then
// one memory read per probe through the single table memory (registered read).
// After reset a clearing pass writes every entry empty with req_stall high; cfg
// writes are taken during it. A finished item sits in the rsp register while the
// next item is accepted and hashed; a stalled rsp only holds the probe walk back
// when its result is ready.
module linear_probe_pair_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int SUM_BITS    = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_item_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_item_t        rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  // only the low SUM_BITS of the sum field form the key
  localparam int KS_W   = (SUM_BITS < SUM_W) ? SUM_BITS : SUM_W;
  // memory word: {occupied, index, sum, payload}
  localparam int WORD_W = 2 + INDEX_W + KS_W;
  localparam int OCC_B  = WORD_W - 1;
  localparam int IDX_LO = KS_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MODW,
    ST_PROBE
  } state_t;

  state_t state;

  logic [CFG_W-1:0] slots_in_use;

  // latched item
  logic               key_kind;
  logic [INDEX_W-1:0] key_idx;
  logic [KS_W-1:0]    key_sum;
  logic               key_bit;
  logic [PROD_W-1:0]  prod_idx;
  logic [PROD_W-1:0]  prod_sum;

  // probe walk
  logic [SLOT_W-1:0] k;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] clr_addr;

  // table memory
  logic [WORD_W-1:0] mem [TABLE_SLOTS];
  logic [WORD_W-1:0] rd_q;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  // remainder unit
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;
  logic [HASH_W-1:0] hash_sum;

  logic [CNT_W-1:0] n_act;
  logic             req_take;
  logic             rsp_free;

  // probe decision
  logic             hit_empty;
  logic             hit_match;
  logic             last_probe;
  logic             finish;
  logic [CNT_W-1:0] kp1;
  logic [SLOT_W-1:0] k_nx;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // modulus: zero acts as one, anything past the table size as the table size
  always_comb begin
    logic [CMP_W-1:0] c;
    c = CMP_W'(slots_in_use);
    if (c == '0) begin
      n_act = CNT_W'(1);
    end else if (c > CMP_W'(TABLE_SLOTS)) begin
      n_act = CNT_W'(TABLE_SLOTS);
    end else begin
      n_act = CNT_W'(c);
    end
  end

  assign hash_sum  = HASH_W'(prod_idx) + HASH_W'(prod_sum);
  assign mod_start = (state == ST_HASH);

  lpht_mod #(
    .MOD_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash_sum),
    .modulus  (n_act),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // one probe per cycle: rd_q holds the entry at k while in ST_PROBE
  always_comb begin
    hit_empty  = !rd_q[OCC_B];
    hit_match  = rd_q[OCC_B] && (key_kind == KIND_LOOKUP)
                 && (rd_q[OCC_B-1:IDX_LO] == key_idx)
                 && (rd_q[KS_W:1] == key_sum);
    last_probe = (cnt + 1'b1) == n_act;
    finish     = hit_empty || hit_match || last_probe;
    kp1        = CNT_W'(k) + 1'b1;
    k_nx       = (kp1 == n_act) ? '0 : SLOT_W'(kp1);
  end

  // read port: home slot as the remainder lands, then the next slot per probe
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_nx;
    if (state == ST_MODW && mod_done) begin
      rd_en   = 1'b1;
      rd_addr = SLOT_W'(mod_rem);
    end else if (state == ST_PROBE && !finish) begin
      rd_en = 1'b1;
    end
  end

  // write port: clearing pass, or the insert into the first empty slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = {1'b1, key_idx, key_sum, key_bit};
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_PROBE && hit_empty && key_kind == KIND_INSERT && rsp_free) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // result taken and no new one loading behind it
      if (rsp_valid && !rsp_stall && !(state == ST_PROBE && finish)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_take) begin
            key_kind <= req.kind;
            key_idx  <= req.item_index;
            key_sum  <= req.partial_sum[KS_W-1:0];
            key_bit  <= req.take_bit;
            prod_idx <= HASH_MUL_INDEX * PROD_W'(req.item_index);
            prod_sum <= HASH_MUL_SUM * PROD_W'(req.partial_sum[KS_W-1:0]);
            state    <= ST_HASH;
          end
        end
        ST_HASH: begin
          state <= ST_MODW;
        end
        ST_MODW: begin
          if (mod_done) begin
            k     <= SLOT_W'(mod_rem);
            cnt   <= '0;
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (!finish) begin
            k   <= k_nx;
            cnt <= cnt + 1'b1;
          end else if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
            if (hit_empty && key_kind == KIND_INSERT) begin
              rsp.found      <= 1'b1;
              rsp.slot       <= SLOT_OUT_W'(k);
              rsp.stored_bit <= key_bit;
              rsp.status     <= STATUS_OK;
            end else if (hit_match) begin
              rsp.found      <= 1'b1;
              rsp.slot       <= SLOT_OUT_W'(k);
              rsp.stored_bit <= rd_q[0];
              rsp.status     <= STATUS_OK;
            end else if (hit_empty) begin
              // lookup miss
              rsp.found      <= 1'b0;
              rsp.slot       <= '0;
              rsp.stored_bit <= 1'b0;
              rsp.status     <= STATUS_OK;
            end else begin
              // every slot in use visited: table full or probe exhausted
              rsp.found      <= 1'b0;
              rsp.slot       <= '0;
              rsp.stored_bit <= 1'b0;
              rsp.status     <= STATUS_FULL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_probe_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (CNT_W'(k) < n_act) && (cnt < n_act))
    else $error("probe slot or count beyond the slots in use");

  a_write_only_on_insert: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != ST_CLEAR) |-> (key_kind == KIND_INSERT) && !rd_q[OCC_B])
    else $error("table written outside an insert into an empty slot");

  a_mod_done_expected: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MODW))
    else $error("remainder finished outside its wait state");

  a_result_from_probe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_PROBE)
    else $error("result loaded without a finished probe walk");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("table read and written in the same cycle");

endmodule

### rtl/lpht_mod.sv
// Multi-cycle restoring remainder unit: dividend mod modulus, four bits per cycle.
module lpht_mod
  import lpht_pkg::*;
#(
  parameter int MOD_W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [MOD_W-1:0]  modulus,
  output logic              done,
  output logic [MOD_W-1:0]  rem
);

  logic                  busy;
  logic [MOD_ITER_W-1:0] iter;
  logic [HASH_W-1:0]     dvd;
  logic [MOD_W-1:0]      rem_nx;
  logic [HASH_W-1:0]     dvd_nx;

  always_comb begin
    logic [MOD_W:0] t;
    rem_nx = rem;
    dvd_nx = dvd;
    for (int j = 0; j < MOD_STEP; j++) begin
      t = {rem_nx, dvd_nx[HASH_W-1]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_nx = t[MOD_W-1:0];
      dvd_nx = {dvd_nx[HASH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
      done <= 1'b0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      iter <= '0;
      dvd  <= dividend;
      rem  <= '0;
      done <= 1'b0;
    end else if (busy) begin
      dvd  <= dvd_nx;
      rem  <= rem_nx;
      iter <= iter + 1'b1;
      done <= (iter == MOD_ITER_W'(MOD_ITERS - 1));
      if (iter == MOD_ITER_W'(MOD_ITERS - 1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("remainder done without a running division");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < modulus)
    else $error("remainder not below modulus");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("division started while busy");

endmodule
